>>> rtl/bzc_pkg.sv
// Shared types, constants and rounding helper for the Bezier curve evaluator.
package bzc_pkg;

    localparam int COORD_W  = 32;
    localparam int T_W      = 17;
    localparam int PIDX_W   = 4;
    localparam int CFG_W    = 5;
    localparam int BINOM_W  = 16;
    localparam int PROD_W   = 64;
    localparam int TERM_W   = 48;

    localparam logic [T_W-1:0] ONE_Q16 = 17'h10000;

    // Stream payload layout, lowest bit first.
    localparam int S_TDATA_W = 120;
    localparam int S_IDX_LSB = 0;
    localparam int S_X_LSB   = 4;
    localparam int S_Y_LSB   = 36;
    localparam int S_Z_LSB   = 68;
    localparam int S_T_LSB   = 100;

    localparam int M_TDATA_W    = 104;
    localparam int M_STATUS_BIT = 0;
    localparam int M_X_LSB      = 1;
    localparam int M_Y_LSB      = 33;
    localparam int M_Z_LSB      = 65;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_EVAL  = 1'b1
    } req_type_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPOW,
        ST_BMUL,
        ST_WMUL,
        ST_XMUL,
        ST_YMUL,
        ST_ZMUL,
        ST_DRAIN,
        ST_REWIND,
        ST_DONE
    } eval_state_t;

    typedef enum logic [1:0] {
        SEL_X,
        SEL_Y,
        SEL_Z
    } coord_sel_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        point_t             pt;
        logic [BINOM_W-1:0] binom;
        logic [T_W-1:0]     pw;
    } cell_data_t;

    typedef struct packed {
        logic rot;
        logic pw_shift;
        logic pas_init;
        logic pas_step;
    } cell_ctrl_t;

    // (p + 0.5) >> 16 for a product of two Q1.16 values no larger than 1.0
    function automatic logic [T_W-1:0] q16_round(input logic [2*T_W-1:0] p);
        logic [2*T_W-1:0] s;
        s = p + (2*T_W)'(32768);
        return s[T_W+15:16];
    endfunction

endpackage

>>> rtl/bezier_curve_evaluator.sv
// Top level of the Bezier curve evaluator: request control, shared multiplier, output register.
//
// Usage
//   Input requests arrive on s_tvalid/s_tready/s_tdata with the kind in s_tuser
//   (write a control point, or evaluate the curve at t). Each request yields one
//   result on m_tvalid/m_tready/m_tdata. cfg_wr_en/cfg_wr_data set the number of
//   control points in use and rebuild the binomial row in the cell ring.
// Sequence
//   One request at a time. A write result is loaded into the output register from the
//   final state once that register is free. An evaluate first builds the (1-t) powers
//   into the ring, then makes five passes of the shared multiplier per point (t-power
//   product, coefficient, x, y, z), adds the last term, rotates the ring home and
//   loads the output. An empty curve goes straight to the load. s_tready rises the
//   cycle after the load; after a configuration write it stays low while the Pascal
//   row is rebuilt.
// Reset
//   Point count 0, each control point at its slot number, output empty.
// Stall
//   The output register holds a result while m_tready is low; the next request is
//   still taken and worked on, and waits in the final state until the register frees.
module bezier_curve_evaluator #(
    parameter int MAX_POINTS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // point_index[3:0], x_in[35:4], y_in[67:36], z_in[99:68], param_t[116:100]
    input  logic [bzc_pkg::S_TDATA_W-1:0]      s_tdata,
    // req_type[0]
    input  logic                               s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // status[0], x_out[32:1], y_out[64:33], z_out[96:65]
    output logic [bzc_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_wr_en,
    input  logic [bzc_pkg::CFG_W-1:0]          cfg_wr_data
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int POS_W = $clog2(MAX_POINTS);
    localparam int ACC_W = bzc_pkg::TERM_W + $clog2(MAX_POINTS);
    localparam int CW    = bzc_pkg::COORD_W;
    localparam int TW    = bzc_pkg::T_W;

    function automatic logic [CW-1:0] mag32(input logic [CW-1:0] v);
        return v[CW-1] ? (~v + CW'(1)) : v;
    endfunction

    function automatic logic [CW-1:0] sat32(input logic [ACC_W-1:0] v);
        logic [ACC_W-CW:0] upper;
        upper = v[ACC_W-1:CW-1];
        if ((&upper) || !(|upper)) begin
            return v[CW-1:0];
        end
        return v[ACC_W-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    endfunction

    // ---------------------------------------------------------------- fields
    logic [bzc_pkg::PIDX_W-1:0] s_idx;
    logic [CW-1:0]              s_x;
    logic [CW-1:0]              s_y;
    logic [CW-1:0]              s_z;
    logic [TW-1:0]              s_t;
    logic [TW-1:0]              t_clamp;

    assign s_idx   = s_tdata[bzc_pkg::S_IDX_LSB +: bzc_pkg::PIDX_W];
    assign s_x     = s_tdata[bzc_pkg::S_X_LSB +: CW];
    assign s_y     = s_tdata[bzc_pkg::S_Y_LSB +: CW];
    assign s_z     = s_tdata[bzc_pkg::S_Z_LSB +: CW];
    assign s_t     = s_tdata[bzc_pkg::S_T_LSB +: TW];
    assign t_clamp = (s_t > bzc_pkg::ONE_Q16) ? bzc_pkg::ONE_Q16 : s_t;

    // ---------------------------------------------------------------- state
    bzc_pkg::eval_state_t state_reg, state_next;

    logic [CNT_W-1:0]          n_reg, n_next;
    logic [CNT_W-1:0]          refill_reg, refill_next;
    logic [CNT_W-1:0]          step_reg, step_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic                      pend_valid_reg, pend_valid_next;

    logic [TW-1:0]             t_reg, u_reg;
    logic [TW-1:0]             pow_reg, pow_next;
    logic [TW-1:0]             b_reg;
    logic [CW-1:0]             w_reg;
    logic [bzc_pkg::PROD_W-1:0] prod_reg;
    bzc_pkg::coord_sel_t       pend_sel_reg;
    logic                      pend_neg_reg;
    logic [ACC_W-1:0]          acc_x_reg, acc_y_reg, acc_z_reg;
    logic                      status_reg;
    logic [bzc_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // ---------------------------------------------------------------- control decode
    logic                      accept;
    logic                      is_eval;
    logic                      idx_ok;
    logic                      out_free;
    logic                      out_load;
    logic                      last_step;
    logic                      pos_last;
    logic [CNT_W-1:0]          cfg_n;
    bzc_pkg::cell_ctrl_t       cell_ctrl;
    bzc_pkg::cell_data_t       head;
    bzc_pkg::point_t           wr_point;
    logic                      wr_go;

    assign is_eval   = (bzc_pkg::req_type_t'(s_tuser) == bzc_pkg::REQ_EVAL);
    assign idx_ok    = int'(s_idx) < int'(n_reg);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_step = (step_reg == n_reg - CNT_W'(1));
    assign pos_last  = (pos_reg == POS_W'(MAX_POINTS - 1));
    assign cfg_n     = (int'(cfg_wr_data) > MAX_POINTS) ? CNT_W'(MAX_POINTS) :
                       CNT_W'(cfg_wr_data);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bzc_pkg::ST_IDLE: begin
                if (accept) begin
                    if (is_eval && (n_reg != '0)) begin
                        state_next = bzc_pkg::ST_UPOW;
                    end else begin
                        state_next = bzc_pkg::ST_DONE;
                    end
                end
            end
            bzc_pkg::ST_UPOW: begin
                if (last_step) begin
                    state_next = bzc_pkg::ST_BMUL;
                end
            end
            bzc_pkg::ST_BMUL: state_next = bzc_pkg::ST_WMUL;
            bzc_pkg::ST_WMUL: state_next = bzc_pkg::ST_XMUL;
            bzc_pkg::ST_XMUL: state_next = bzc_pkg::ST_YMUL;
            bzc_pkg::ST_YMUL: state_next = bzc_pkg::ST_ZMUL;
            bzc_pkg::ST_ZMUL: begin
                state_next = last_step ? bzc_pkg::ST_DRAIN : bzc_pkg::ST_BMUL;
            end
            bzc_pkg::ST_DRAIN: begin
                state_next = (pos_reg == '0) ? bzc_pkg::ST_DONE : bzc_pkg::ST_REWIND;
            end
            bzc_pkg::ST_REWIND: begin
                if (pos_last) begin
                    state_next = bzc_pkg::ST_DONE;
                end
            end
            bzc_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = bzc_pkg::ST_IDLE;
                end
            end
            default: state_next = bzc_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_tready           = 1'b0;
        out_load           = 1'b0;
        cell_ctrl.rot      = 1'b0;
        cell_ctrl.pw_shift = 1'b0;
        cell_ctrl.pas_init = cfg_wr_en;
        cell_ctrl.pas_step = (refill_reg != '0) && !cfg_wr_en;
        case (state_reg)
            bzc_pkg::ST_IDLE:   s_tready = (refill_reg == '0) && !cfg_wr_en;
            bzc_pkg::ST_UPOW:   cell_ctrl.pw_shift = 1'b1;
            bzc_pkg::ST_ZMUL:   cell_ctrl.rot = 1'b1;
            bzc_pkg::ST_REWIND: cell_ctrl.rot = 1'b1;
            bzc_pkg::ST_DONE:   out_load = out_free;
            default: ;
        endcase
    end

    assign accept   = s_tvalid && s_tready;
    assign wr_go    = accept && !is_eval && idx_ok;
    assign wr_point = '{x: s_x, y: s_y, z: s_z};

    // ---------------------------------------------------------------- cell ring
    bzc_chain #(
        .MAX_POINTS (MAX_POINTS)
    ) u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (cell_ctrl),
        .wr_en    (wr_go),
        .wr_index (s_idx),
        .wr_point (wr_point),
        .pw_in    (pow_reg),
        .head     (head)
    );

    // ---------------------------------------------------------------- arithmetic
    // Power unit: (1-t) powers during the first pass, t powers while walking points.
    logic [2*TW-1:0]            pow_prod;
    logic [TW-1:0]              pow_q;
    logic [CW-1:0]              mul_a, mul_b;
    logic [bzc_pkg::PROD_W-1:0] mul_p;
    logic [CW-1:0]              coord_sel;
    logic [bzc_pkg::PROD_W-1:0] term_sum;
    logic [ACC_W-1:0]           term_ext;
    logic [ACC_W-1:0]           term_add;

    assign pow_prod = pow_reg * ((state_reg == bzc_pkg::ST_UPOW) ? u_reg : t_reg);
    assign pow_q    = bzc_pkg::q16_round(pow_prod);

    always_comb begin
        coord_sel = head.pt.x;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            bzc_pkg::ST_BMUL: begin
                mul_a = CW'(head.pw);
                mul_b = CW'(pow_reg);
            end
            bzc_pkg::ST_WMUL: begin
                mul_a = CW'(head.binom);
                mul_b = CW'(b_reg);
            end
            bzc_pkg::ST_XMUL: begin
                coord_sel = head.pt.x;
                mul_a     = mag32(head.pt.x);
                mul_b     = w_reg;
            end
            bzc_pkg::ST_YMUL: begin
                coord_sel = head.pt.y;
                mul_a     = mag32(head.pt.y);
                mul_b     = w_reg;
            end
            bzc_pkg::ST_ZMUL: begin
                coord_sel = head.pt.z;
                mul_a     = mag32(head.pt.z);
                mul_b     = w_reg;
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Round the registered product at bit 16, then apply the point's sign
    assign term_sum = prod_reg + bzc_pkg::PROD_W'(32768);
    assign term_ext = ACC_W'(term_sum[bzc_pkg::PROD_W-1:16]);
    assign term_add = pend_neg_reg ? (~term_ext + ACC_W'(1)) : term_ext;

    // ---------------------------------------------------------------- counters
    always_comb begin
        n_next          = n_reg;
        refill_next     = refill_reg;
        step_next       = step_reg;
        pos_next        = pos_reg;
        m_tvalid_next   = m_tvalid_reg;
        pend_valid_next = 1'b0;
        pow_next        = pow_reg;

        if (cfg_wr_en) begin
            n_next      = cfg_n;
            refill_next = (cfg_n == '0) ? '0 : cfg_n - CNT_W'(1);
        end else if (refill_reg != '0) begin
            refill_next = refill_reg - CNT_W'(1);
        end

        if (accept) begin
            step_next = '0;
            pow_next  = bzc_pkg::ONE_Q16;
        end

        case (state_reg)
            bzc_pkg::ST_UPOW: begin
                step_next = last_step ? '0 : step_reg + CNT_W'(1);
                pow_next  = last_step ? bzc_pkg::ONE_Q16 : pow_q;
            end
            bzc_pkg::ST_WMUL: pow_next = pow_q;
            bzc_pkg::ST_XMUL: pend_valid_next = 1'b1;
            bzc_pkg::ST_YMUL: pend_valid_next = 1'b1;
            bzc_pkg::ST_ZMUL: begin
                pend_valid_next = 1'b1;
                step_next       = step_reg + CNT_W'(1);
                pos_next        = pos_last ? '0 : pos_reg + POS_W'(1);
            end
            bzc_pkg::ST_REWIND: pos_next = pos_last ? '0 : pos_reg + POS_W'(1);
            default: ;
        endcase

        // Hold a result until taken; a new one replaces it in the same cycle
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[bzc_pkg::M_STATUS_BIT]     = status_reg;
        m_tdata_next[bzc_pkg::M_X_LSB +: CW]    = sat32(acc_x_reg);
        m_tdata_next[bzc_pkg::M_Y_LSB +: CW]    = sat32(acc_y_reg);
        m_tdata_next[bzc_pkg::M_Z_LSB +: CW]    = sat32(acc_z_reg);
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bzc_pkg::ST_IDLE;
            n_reg          <= '0;
            refill_reg     <= '0;
            step_reg       <= '0;
            pos_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            n_reg          <= n_next;
            refill_reg     <= refill_next;
            step_reg       <= step_next;
            pos_reg        <= pos_next;
            m_tvalid_reg   <= m_tvalid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pow_reg <= pow_next;
        if (accept) begin
            t_reg      <= t_clamp;
            u_reg      <= bzc_pkg::ONE_Q16 - t_clamp;
            status_reg <= (!is_eval && !idx_ok) ? bzc_pkg::STATUS_RANGE : bzc_pkg::STATUS_OK;
            acc_x_reg  <= '0;
            acc_y_reg  <= '0;
            acc_z_reg  <= '0;
        end else if (pend_valid_reg) begin
            case (pend_sel_reg)
                bzc_pkg::SEL_X: acc_x_reg <= acc_x_reg + term_add;
                bzc_pkg::SEL_Y: acc_y_reg <= acc_y_reg + term_add;
                bzc_pkg::SEL_Z: acc_z_reg <= acc_z_reg + term_add;
                default: ;
            endcase
        end
        if (state_reg == bzc_pkg::ST_BMUL) begin
            b_reg <= bzc_pkg::q16_round(mul_p[2*TW-1:0]);
        end
        if (state_reg == bzc_pkg::ST_WMUL) begin
            w_reg <= mul_p[CW-1:0];
        end
        prod_reg     <= mul_p;
        pend_neg_reg <= coord_sel[CW-1];
        case (state_reg)
            bzc_pkg::ST_YMUL: pend_sel_reg <= bzc_pkg::SEL_Y;
            bzc_pkg::ST_ZMUL: pend_sel_reg <= bzc_pkg::SEL_Z;
            default:          pend_sel_reg <= bzc_pkg::SEL_X;
        endcase
        if (out_load) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/bzc_cell.sv
// One cell of the control point ring: point, binomial coefficient and power.
module bzc_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  bzc_pkg::cell_ctrl_t                ctrl,
    input  logic                               wr_en,
    input  bzc_pkg::point_t                    wr_point,
    input  bzc_pkg::cell_data_t                rot_in,
    input  logic [bzc_pkg::T_W-1:0]            pw_in,
    input  logic [bzc_pkg::BINOM_W-1:0]        binom_left,
    output bzc_pkg::cell_data_t                data_out
);

    localparam logic [bzc_pkg::COORD_W-1:0] RESET_COORD =
        bzc_pkg::COORD_W'(CELL_IDX) << 16;

    bzc_pkg::cell_data_t              data_reg;
    bzc_pkg::cell_data_t              data_next;
    logic [bzc_pkg::BINOM_W:0]        pas_sum;

    always_comb begin
        data_next = data_reg;
        pas_sum   = {1'b0, binom_left} + {1'b0, data_reg.binom};
        if (ctrl.rot) begin
            data_next = rot_in;
        end
        if (ctrl.pw_shift) begin
            data_next.pw = pw_in;
        end
        if (wr_en) begin
            data_next.pt = wr_point;
        end
        // Pascal step saturates at the top of the coefficient range
        if (ctrl.pas_init) begin
            data_next.binom = (CELL_IDX == 0) ? bzc_pkg::BINOM_W'(1) : '0;
        end else if (ctrl.pas_step) begin
            data_next.binom = pas_sum[bzc_pkg::BINOM_W] ? '1 :
                              pas_sum[bzc_pkg::BINOM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg.pt.x  <= RESET_COORD;
            data_reg.pt.y  <= RESET_COORD;
            data_reg.pt.z  <= RESET_COORD;
            data_reg.binom <= bzc_pkg::BINOM_W'(1);
            data_reg.pw    <= '0;
        end else begin
            data_reg <= data_next;
        end
    end

    assign data_out = data_reg;

endmodule

>>> rtl/bzc_chain.sv
// Ring of control point cells with write decode and neighbor wiring.
module bzc_chain #(
    parameter int MAX_POINTS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bzc_pkg::cell_ctrl_t            ctrl,
    input  logic                           wr_en,
    input  logic [bzc_pkg::PIDX_W-1:0]     wr_index,
    input  bzc_pkg::point_t                wr_point,
    input  logic [bzc_pkg::T_W-1:0]        pw_in,
    output bzc_pkg::cell_data_t            head
);

    bzc_pkg::cell_data_t cell_q [MAX_POINTS];

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        logic                          wr_hit;
        logic [bzc_pkg::T_W-1:0]       pw_left;
        logic [bzc_pkg::BINOM_W-1:0]   binom_left;

        if (g < (1 << bzc_pkg::PIDX_W)) begin : g_wr
            assign wr_hit = wr_en && (wr_index == bzc_pkg::PIDX_W'(g));
        end else begin : g_nowr
            assign wr_hit = 1'b0;
        end

        // Powers enter at the head and move up the ring; cell 0 sees no left coefficient
        if (g == 0) begin : g_first
            assign pw_left    = pw_in;
            assign binom_left = '0;
        end else begin : g_rest
            assign pw_left    = cell_q[g-1].pw;
            assign binom_left = cell_q[g-1].binom;
        end

        bzc_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .wr_en      (wr_hit),
            .wr_point   (wr_point),
            .rot_in     (cell_q[(g + 1) % MAX_POINTS]),
            .pw_in      (pw_left),
            .binom_left (binom_left),
            .data_out   (cell_q[g])
        );
    end

    assign head = cell_q[0];

endmodule

>>> rtl/bzc_checker.sv
// Port-level checks for the Bezier curve evaluator, bound to the top level.
module bzc_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [bzc_pkg::M_TDATA_W-1:0]      m_tdata,
    input logic                               m_tvalid,
    input logic                               m_tready
);

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // No result leaves right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // One request in flight: no accept in the cycle after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in work");

    // A rejected write carries a zero point
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[bzc_pkg::M_STATUS_BIT] == bzc_pkg::STATUS_RANGE) |->
        (m_tdata[bzc_pkg::M_Z_LSB + bzc_pkg::COORD_W - 1:bzc_pkg::M_X_LSB] == '0))
        else $error("out-of-range write returned nonzero coordinates");

endmodule

bind bezier_curve_evaluator bzc_checker u_bzc_checker (.*);

>>> verif/bezier_curve_evaluator_test.sv
// Self-checking testbench for the Bezier curve evaluator: directed and random requests.
module bezier_curve_evaluator_test;

    localparam int NUM_SLOTS     = 16;
    localparam int TARGET_ITEMS  = 1200;
    localparam int QUIET_FROM    = 1050;
    localparam int IDLE_LIMIT    = 3000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 20;
    localparam int TAIL_CYCLES   = 150;

    typedef struct {
        bzc_pkg::req_type_t          kind;
        logic [bzc_pkg::PIDX_W-1:0]  idx;
        logic [bzc_pkg::COORD_W-1:0] x;
        logic [bzc_pkg::COORD_W-1:0] y;
        logic [bzc_pkg::COORD_W-1:0] z;
        logic [bzc_pkg::T_W-1:0]     t;
    } curve_request_t;

    typedef struct {
        logic                        status;
        logic [bzc_pkg::COORD_W-1:0] x;
        logic [bzc_pkg::COORD_W-1:0] y;
        logic [bzc_pkg::COORD_W-1:0] z;
    } curve_result_t;

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic [bzc_pkg::S_TDATA_W-1:0]   s_tdata     = '0;
    logic                            s_tuser     = 1'b0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    logic [bzc_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic                            cfg_wr_en   = 1'b0;
    logic [bzc_pkg::CFG_W-1:0]       cfg_wr_data = '0;

    // Requests still to send, and the results owed by the block, oldest first.
    curve_request_t requests_to_send[$];
    curve_result_t  results_due[$];

    int   mismatch_count = 0;
    int   requests_made  = 0;
    int   idle_cycles    = 0;
    int   send_gap       = 0;
    int   recv_gap       = 0;
    int   hold_left      = 0;
    logic hold_done      = 1'b0;
    logic want_long_hold = 1'b0;
    logic quiet          = 1'b0;

    // Shadow state of the block: control points, binomial row and point count.
    logic signed [bzc_pkg::COORD_W-1:0] shadow_x[NUM_SLOTS];
    logic signed [bzc_pkg::COORD_W-1:0] shadow_y[NUM_SLOTS];
    logic signed [bzc_pkg::COORD_W-1:0] shadow_z[NUM_SLOTS];
    logic [bzc_pkg::BINOM_W-1:0]        shadow_binom[NUM_SLOTS];
    logic [bzc_pkg::CFG_W-1:0]          shadow_count;

    bezier_curve_evaluator #(.MAX_POINTS(NUM_SLOTS)) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int active_points();
        return (shadow_count > NUM_SLOTS) ? NUM_SLOTS : int'(shadow_count);
    endfunction

    function automatic longint unsigned q16_mul(longint unsigned a, longint unsigned b);
        return (a * b + 64'd32768) >> 16;
    endfunction

    function automatic longint unsigned q16_pow(longint unsigned base, int k);
        longint unsigned p;
        p = 64'd65536;
        for (int j = 0; j < k; j++)
            p = q16_mul(p, base);
        return p;
    endfunction

    // Round |c| * w at bit 16, half away from zero, and put the sign back.
    function automatic longint weigh_coord(logic signed [bzc_pkg::COORD_W-1:0] c,
                                           longint unsigned w);
        longint          p;
        longint unsigned mag;
        longint unsigned rounded;
        p       = c;
        mag     = (p < 0) ? -p : p;
        rounded = (mag * w + 64'd32768) >> 16;
        return (p < 0) ? -longint'(rounded) : longint'(rounded);
    endfunction

    function automatic logic [bzc_pkg::COORD_W-1:0] clamp_coord(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[bzc_pkg::COORD_W-1:0];
    endfunction

    // Rebuild the Pascal row for the active count; an empty curve leaves it alone.
    function automatic void refill_binomials();
        int row[NUM_SLOTS];
        int n;
        n = active_points();
        if (n == 0)
            return;
        row[0] = 1;
        for (int k = 1; k < n; k++) begin
            row[k] = 1;
            for (int j = k - 1; j >= 1; j--)
                row[j] = row[j - 1] + row[j];
        end
        for (int j = 0; j < n; j++)
            shadow_binom[j] = (row[j] > 65535) ? 16'hFFFF : bzc_pkg::BINOM_W'(row[j]);
    endfunction

    // Apply one request to the shadow state and return the result it must produce.
    function automatic curve_result_t curve_response(curve_request_t r);
        curve_result_t   res;
        int              n;
        longint unsigned tt;
        longint unsigned uu;
        longint unsigned w;
        longint          sx;
        longint          sy;
        longint          sz;
        res = '{status: bzc_pkg::STATUS_OK, x: '0, y: '0, z: '0};
        n   = active_points();
        if (r.kind == bzc_pkg::REQ_WRITE) begin
            if (int'(r.idx) < n) begin
                shadow_x[r.idx] = r.x;
                shadow_y[r.idx] = r.y;
                shadow_z[r.idx] = r.z;
            end else begin
                res.status = bzc_pkg::STATUS_RANGE;
            end
        end else begin
            tt = (r.t > bzc_pkg::ONE_Q16) ? 64'd65536 : 64'(r.t);
            uu = 64'd65536 - tt;
            sx = 0;
            sy = 0;
            sz = 0;
            for (int i = 0; i < n; i++) begin
                w  = 64'(shadow_binom[i]) * q16_mul(q16_pow(uu, n - 1 - i), q16_pow(tt, i));
                sx += weigh_coord(shadow_x[i], w);
                sy += weigh_coord(shadow_y[i], w);
                sz += weigh_coord(shadow_z[i], w);
            end
            res.x = clamp_coord(sx);
            res.y = clamp_coord(sy);
            res.z = clamp_coord(sz);
        end
        return res;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic flag_mismatch(string what, logic [bzc_pkg::COORD_W-1:0] got,
                                 logic [bzc_pkg::COORD_W-1:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(logic [bzc_pkg::M_TDATA_W-1:0] data);
        curve_result_t want;
        if (results_due.size() == 0) begin
            flag_mismatch("result with no request pending",
                          data[bzc_pkg::M_X_LSB +: bzc_pkg::COORD_W], '0);
            return;
        end
        want = results_due.pop_front();
        if (data[bzc_pkg::M_STATUS_BIT] !== want.status)
            flag_mismatch("status", 32'(data[bzc_pkg::M_STATUS_BIT]), 32'(want.status));
        if (data[bzc_pkg::M_X_LSB +: bzc_pkg::COORD_W] !== want.x)
            flag_mismatch("x_out", data[bzc_pkg::M_X_LSB +: bzc_pkg::COORD_W], want.x);
        if (data[bzc_pkg::M_Y_LSB +: bzc_pkg::COORD_W] !== want.y)
            flag_mismatch("y_out", data[bzc_pkg::M_Y_LSB +: bzc_pkg::COORD_W], want.y);
        if (data[bzc_pkg::M_Z_LSB +: bzc_pkg::COORD_W] !== want.z)
            flag_mismatch("z_out", data[bzc_pkg::M_Z_LSB +: bzc_pkg::COORD_W], want.z);
    endtask

    // ---------------------------------------------------------------- driver

    function automatic logic [bzc_pkg::S_TDATA_W-1:0] pack_request(curve_request_t r);
        logic [bzc_pkg::S_TDATA_W-1:0] d;
        d = '0;
        d[bzc_pkg::S_IDX_LSB +: bzc_pkg::PIDX_W]  = r.idx;
        d[bzc_pkg::S_X_LSB   +: bzc_pkg::COORD_W] = r.x;
        d[bzc_pkg::S_Y_LSB   +: bzc_pkg::COORD_W] = r.y;
        d[bzc_pkg::S_Z_LSB   +: bzc_pkg::COORD_W] = r.z;
        d[bzc_pkg::S_T_LSB   +: bzc_pkg::T_W]     = r.t;
        return d;
    endfunction

    // On each accept, predict the result and present the next request. A request
    // that is on offer stays on offer until it is taken.
    always @(posedge aclk) begin : request_driver
        logic taken;
        taken = s_tvalid && s_tready;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (taken)
                results_due.push_back(curve_response(requests_to_send.pop_front()));
            if (s_tvalid && !taken) begin
                // hold the current request
            end else if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(0, 16);
                s_tvalid <= 1'b0;
            end else if (requests_to_send.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pack_request(requests_to_send[0]);
                s_tuser  <= requests_to_send[0].kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    // Count down one long receiver hold-off once the stimulus asks for it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (want_long_hold && !hold_done) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (quiet) begin
                m_tready <= 1'b1;
            end else if (recv_gap != 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                recv_gap <= $urandom_range(0, 16);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stop a hung run: too many cycles in a row with no request or result moving.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic queue_request(bzc_pkg::req_type_t kind, int idx,
                                 logic [bzc_pkg::COORD_W-1:0] x,
                                 logic [bzc_pkg::COORD_W-1:0] y,
                                 logic [bzc_pkg::COORD_W-1:0] z,
                                 logic [bzc_pkg::T_W-1:0] t);
        curve_request_t r;
        r = '{kind: kind, idx: bzc_pkg::PIDX_W'(idx), x: x, y: y, z: z, t: t};
        requests_to_send.push_back(r);
        requests_made++;
    endtask

    function automatic logic [bzc_pkg::COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        endcase
    endfunction

    function automatic logic [bzc_pkg::T_W-1:0] pick_param();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return bzc_pkg::ONE_Q16;
            2:       return bzc_pkg::T_W'($urandom_range(32'h10001, 32'h1FFFF));
            default: return bzc_pkg::T_W'($urandom_range(0, 32'h10000));
        endcase
    endfunction

    // Wait until the block owes nothing, then let the evaluation pipe empty.
    task automatic settle();
        while (requests_to_send.size() != 0 || results_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write point_count and mirror it into the shadow state.
    task automatic set_point_count(logic [bzc_pkg::CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        shadow_count = value;
        refill_binomials();
        @(negedge aclk);
    endtask

    // One random phase: a new count, usually a full set of control points, then a
    // mix of evaluations and writes, most of them to slots in use.
    task automatic random_phase();
        logic [bzc_pkg::CFG_W-1:0]   count;
        logic [bzc_pkg::COORD_W-1:0] same;
        logic                        one_value;
        int                          n;
        int                          extra;
        settle();
        case ($urandom_range(0, 9))
            0:       count = '0;
            1:       count = bzc_pkg::CFG_W'($urandom_range(17, 31));
            2:       count = bzc_pkg::CFG_W'(NUM_SLOTS);
            default: count = bzc_pkg::CFG_W'($urandom_range(1, 16));
        endcase
        set_point_count(count);
        n = active_points();
        if (n > 0 && $urandom_range(0, 3) != 0) begin
            // all points at one extreme pushes the rounded sum toward saturation
            one_value = ($urandom_range(0, 3) == 0);
            same      = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            for (int i = 0; i < n; i++) begin
                if (one_value)
                    queue_request(bzc_pkg::REQ_WRITE, i, same, same, same, pick_param());
                else
                    queue_request(bzc_pkg::REQ_WRITE, i, pick_coord(), pick_coord(),
                                  pick_coord(), pick_param());
            end
        end
        extra = $urandom_range(20, 50);
        repeat (extra) begin
            if ($urandom_range(0, 9) < 6)
                queue_request(bzc_pkg::REQ_EVAL, $urandom_range(0, 15), $urandom, $urandom,
                              $urandom, pick_param());
            else if (n > 0 && $urandom_range(0, 3) != 0)
                queue_request(bzc_pkg::REQ_WRITE, $urandom_range(0, n - 1), pick_coord(),
                              pick_coord(), pick_coord(), pick_param());
            else
                queue_request(bzc_pkg::REQ_WRITE, $urandom_range(0, 15), pick_coord(),
                              pick_coord(), pick_coord(), pick_param());
        end
    endtask

    initial begin
        int phase;
        shadow_count = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            shadow_x[i]     = bzc_pkg::COORD_W'(i * 65536);
            shadow_y[i]     = bzc_pkg::COORD_W'(i * 65536);
            shadow_z[i]     = bzc_pkg::COORD_W'(i * 65536);
            shadow_binom[i] = 16'd1;
        end

        // Hold reset, then release it for good.
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty curve straight out of reset: zero point, every write out of range.
        queue_request(bzc_pkg::REQ_EVAL, 0, '0, '0, '0, '0);
        queue_request(bzc_pkg::REQ_WRITE, 0, 32'h1234_5678, 32'h1, 32'h2, bzc_pkg::ONE_Q16);

        // Three points on their reset positions, then field extremes.
        settle();
        set_point_count(5'd3);
        queue_request(bzc_pkg::REQ_EVAL, 0, '0, '0, '0, 17'h08000);
        queue_request(bzc_pkg::REQ_WRITE, 2, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                      17'h1FFFF);
        queue_request(bzc_pkg::REQ_WRITE, 3, 32'h1, 32'h1, 32'h1, '0);
        queue_request(bzc_pkg::REQ_WRITE, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      17'h1FFFF);
        queue_request(bzc_pkg::REQ_EVAL, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
        queue_request(bzc_pkg::REQ_EVAL, 0, '0, '0, '0, bzc_pkg::ONE_Q16);
        queue_request(bzc_pkg::REQ_EVAL, 0, '0, '0, '0, 17'h1FFFF);
        queue_request(bzc_pkg::REQ_EVAL, 0, '0, '0, '0, 17'h00001);

        // Count above the slot total clamps to sixteen points.
        settle();
        set_point_count(5'd31);
        queue_request(bzc_pkg::REQ_WRITE, 15, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0);
        queue_request(bzc_pkg::REQ_WRITE, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
        queue_request(bzc_pkg::REQ_EVAL, 0, '0, '0, '0, 17'h0FFFF);
        queue_request(bzc_pkg::REQ_EVAL, 0, '0, '0, '0, 17'h08000);

        // Back to an empty curve by an explicit write of zero.
        settle();
        set_point_count(5'd0);
        queue_request(bzc_pkg::REQ_EVAL, 0, '0, '0, '0, 17'd12345);
        queue_request(bzc_pkg::REQ_WRITE, 0, 32'h5, 32'h6, 32'h7, '0);

        // Single point: the curve is that point for any t.
        settle();
        set_point_count(5'd1);
        queue_request(bzc_pkg::REQ_WRITE, 0, 32'hFFFF_0000, 32'h0001_8000, 32'h8000_0001, '0);
        queue_request(bzc_pkg::REQ_EVAL, 0, '0, '0, '0, 17'h10001);
        queue_request(bzc_pkg::REQ_WRITE, 1, 32'h9, 32'h9, 32'h9, '0);

        // Two points: slot 1 still holds its reset value across count writes.
        settle();
        set_point_count(5'd2);
        queue_request(bzc_pkg::REQ_EVAL, 0, '0, '0, '0, 17'h08000);

        phase = 0;
        while (requests_made < TARGET_ITEMS) begin
            if (requests_made >= QUIET_FROM)
                quiet = 1'b1;
            random_phase();
            // keep the receiver off while requests pile up behind a full block
            if (phase == 2)
                want_long_hold = 1'b1;
            phase++;
        end

        while (requests_to_send.size() != 0 || results_due.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
